// ----- hdl/rebd_pkg.sv -----
// shared types, register indexes and the quadrature transition rule
package rebd_pkg;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int POS_W       = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS = 1'b1;

  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST = 16'd1000;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  // previous phase in the top two bits, current phase in the low two
  function automatic dir_t turn_dir(input logic [3:0] code);
    dir_t d;
    case (code) inside
      4'b1101, 4'b0100, 4'b0010, 4'b1011: d = DIR_CW;
      4'b1110, 4'b0111, 4'b0001, 4'b1000: d = DIR_CCW;
      default:                            d = DIR_NONE;
    endcase
    return d;
  endfunction

endpackage

// ----- hdl/rotary_encoder_button_decoder_top.sv -----
// rotary encoder and push switch decoder with debounce and press length classing
//
//  channel | direction | words                                  | handshake
//  in_     | input     | clk_level, dt_level, button_level      | in_valid / in_ready
//  out_    | output    | turn_direction, short/long_press, pos  | out_valid / out_ready
//  cfg_    | input     | debounce (0), long press (1) limits    | cfg_we, no wait
//
// one word in, one word out; out_valid rises once an accepted word has moved from
// the sample register to the result register; a new word can enter every cycle
// unless stalled. the state update and result are combinational between the two.
// reset zeroes encoder and tick state, sets switch to released, loads default limits.
// a stall on out_ready holds the result word and back-pressures the sample register.
module rotary_encoder_button_decoder_top
  import rebd_pkg::*;
#(
  parameter int COUNT_WIDTH = 32,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_clk_level,
  input  logic                    in_dt_level,
  input  logic                    in_button_level,

  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_turn_direction,
  output logic                    out_short_press,
  output logic                    out_long_press,
  output logic signed [POS_W-1:0] out_position,

  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  logic [CFG_DATA_W-1:0]  debounce_r;
  logic [CFG_DATA_W-1:0]  long_limit_r;

  logic                   s1_valid_r;
  logic                   s1_clk_r;
  logic                   s1_dt_r;
  logic                   s1_btn_r;

  logic [1:0]             prev_phase_r;
  logic [COUNT_WIDTH-1:0] step_count_r;
  logic                   button_prev_r;
  logic [TIME_WIDTH-1:0]  tick_now_r;
  logic [TIME_WIDTH-1:0]  last_change_r;
  logic [TIME_WIDTH-1:0]  press_start_r;

  logic                   out_valid_r;
  dir_t                   dir_r;
  logic                   short_r;
  logic                   long_r;
  logic [COUNT_WIDTH-1:0] pos_r;

  logic                   adv;
  logic [1:0]             phase;
  dir_t                   dir_nxt;
  logic [COUNT_WIDTH-1:0] step_count_nxt;
  logic [TIME_WIDTH-1:0]  since;
  logic [TIME_WIDTH-1:0]  held;
  logic [TIME_WIDTH-1:0]  debounce_ext;
  logic [TIME_WIDTH-1:0]  long_ext;
  logic                   change_ok;
  logic                   short_nxt;
  logic                   long_nxt;

  // sample register moves on when the result register is free or being emptied
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  assign debounce_ext = TIME_WIDTH'(debounce_r);
  assign long_ext     = TIME_WIDTH'(long_limit_r);

  always_comb begin
    phase   = {s1_clk_r, s1_dt_r};
    dir_nxt = turn_dir({prev_phase_r, phase});
    case (dir_nxt)
      DIR_CW:  step_count_nxt = step_count_r + 1'b1;
      DIR_CCW: step_count_nxt = step_count_r - 1'b1;
      default: step_count_nxt = step_count_r;
    endcase

    since     = tick_now_r - last_change_r;
    held      = tick_now_r - press_start_r;
    change_ok = (s1_btn_r != button_prev_r) && (since >= debounce_ext);
    long_nxt  = change_ok && s1_btn_r && (held >= long_ext);
    short_nxt = change_ok && s1_btn_r && !(held >= long_ext) && (held > debounce_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_limit_r <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE:   debounce_r   <= cfg_wdata;
        CFG_LONG_PRESS: long_limit_r <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_clk_r <= in_clk_level;
      s1_dt_r  <= in_dt_level;
      s1_btn_r <= in_button_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_phase_r  <= 2'b00;
      step_count_r  <= '0;
      button_prev_r <= 1'b1;
      tick_now_r    <= '0;
      last_change_r <= '0;
      press_start_r <= '0;
    end else if (adv) begin
      prev_phase_r <= phase;
      step_count_r <= step_count_nxt;
      tick_now_r   <= tick_now_r + 1'b1;
      if (change_ok) begin
        button_prev_r <= s1_btn_r;
        last_change_r <= tick_now_r;
        if (!s1_btn_r) begin
          press_start_r <= tick_now_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dir_r   <= dir_nxt;
      short_r <= short_nxt;
      long_r  <= long_nxt;
      pos_r   <= step_count_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_turn_direction = dir_r;
  assign out_short_press    = short_r;
  assign out_long_press     = long_r;
  // sign-extend or truncate the running count to the port width
  assign out_position       = POS_W'(signed'(pos_r));

  a_press_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_short_press && out_long_press))
    else $error("short and long press flagged on one word");

  a_cw_step: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && dir_nxt == DIR_CW) |=>
      step_count_r == COUNT_WIDTH'($past(step_count_r) + 1'b1))
    else $error("clockwise step did not advance the count");

  a_press_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (short_nxt || long_nxt)) |=> (button_prev_r == 1'b1 && out_valid))
    else $error("press reported without an accepted release");

  a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> tick_now_r == TIME_WIDTH'($past(tick_now_r) + 1'b1))
    else $error("tick did not advance by one per word");

endmodule
